@@ rtl/frbv_pkg.sv @@
`default_nettype none

package frbv_pkg;

   // Fixed field widths of the request and response channels
   localparam int OpcodeWidth = 2;
   localparam int ValueWidth  = 16;
   localparam int StatusWidth = 2;

   typedef logic [OpcodeWidth-1:0] opcode_type;
   typedef logic [StatusWidth-1:0] status_type;

   // Request operations
   localparam opcode_type OP_ENQUEUE = 2'd0;
   localparam opcode_type OP_DEQUEUE = 2'd1;
   localparam opcode_type OP_REMOVE  = 2'd2;

   // Response status codes
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;      // the first free cell takes the broadcast value
      logic capture;  // every cell compares its entry with the broadcast value
   } cell_cmd_type;

endpackage

`default_nettype wire

@@ rtl/fifo_with_remove_by_value_top.sv @@
`default_nettype none

// Channel    Ports                                              Role
// request    req_valid req_ready req_opcode req_value           operation in
// response   rsp_valid rsp_ready rsp_status rsp_head_value      result out
//            rsp_occupancy
//
// Enqueue, dequeue and refused operations finish in the idle state; a remove on
// a non-empty queue enters the shift state: the chain compares every cell, and
// on a hit shifts every cell from the first hit onwards down by one next cycle.
// A finished result waits in an output register; while it is stalled the
// block still takes one more request and parks its result in a holding stage.
// Reset clears the cell valid bits and the count; no clearing pass is needed.

module fifo_with_remove_by_value_top #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire frbv_pkg::opcode_type             req_opcode,
   input  wire logic [frbv_pkg::ValueWidth-1:0]  req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output frbv_pkg::status_type                  rsp_status,
   output logic [frbv_pkg::ValueWidth-1:0]       rsp_head_value,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_occupancy
);
   import frbv_pkg::*;

   localparam int CountBits = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SHIFT = 3'b010,
      S_HOLD  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CountBits-1:0]  count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ValueWidth-1:0] rsp_head_ff, rsp_head_in;
   logic [CountBits-1:0]  rsp_count_ff, rsp_count_in;

   status_type            pend_status_ff, pend_status_in;
   logic [ValueWidth-1:0] pend_head_ff, pend_head_in;
   logic [CountBits-1:0]  pend_count_ff, pend_count_in;

   cell_cmd_type          cmd;
   logic [DEPTH-1:0]      shift_mask;
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_match;
   logic [VALUE_BITS-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]      lowest_match;
   logic [DEPTH-1:0]      remove_mask;
   logic [VALUE_BITS-1:0] din;

   logic                  accept;
   logic                  out_free;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  res_valid;
   status_type            res_status;
   logic [ValueWidth-1:0] res_head;

   assign din         = VALUE_BITS'(req_value);
   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign queue_full  = (count_ff == CountBits'(DEPTH));
   assign queue_empty = (count_ff == '0);

   // Cells from the first match upwards shift down by one
   assign lowest_match = cell_match & (~cell_match + DEPTH'(1));
   assign remove_mask  = ~(lowest_match - DEPTH'(1));

   // Decode the operation and drive the chain
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmd         = '0;
      shift_mask  = '0;
      res_valid   = 1'b0;
      res_status  = ST_OK;
      res_head    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid = 1'b1;
               case (req_opcode)
                  OP_ENQUEUE: begin
                     if (queue_full) begin
                        res_status = ST_FULL;
                     end else begin
                        cmd.enq  = 1'b1;
                        count_in = count_ff + CountBits'(1);
                     end
                  end
                  OP_DEQUEUE: begin
                     if (queue_empty) begin
                        res_status = ST_EMPTY;
                     end else begin
                        shift_mask = '1;
                        res_head   = ValueWidth'(cell_value[0]);
                        count_in   = count_ff - CountBits'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (queue_empty) begin
                        res_status = ST_EMPTY;
                     end else begin
                        cmd.capture = 1'b1;
                        res_valid   = 1'b0;
                        state_in    = S_SHIFT;
                     end
                  end
                  default: begin
                     res_status = ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            res_valid = 1'b1;
            if (|cell_match) begin
               shift_mask = remove_mask;
               count_in   = count_ff - CountBits'(1);
            end else begin
               res_status = ST_NOTFOUND;
            end
            state_in = S_IDLE;
         end
         S_HOLD: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Park the result when the output register is still occupied
      if (res_valid && !out_free) begin
         state_in = S_HOLD;
      end
   end

   // Load the output register from a fresh result or from the holding stage
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_count_in   = rsp_count_ff;
      pend_status_in = pend_status_ff;
      pend_head_in   = pend_head_ff;
      pend_count_in  = pend_count_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_head_in   = res_head;
         rsp_count_in  = count_in;
      end else if (res_valid) begin
         pend_status_in = res_status;
         pend_head_in   = res_head;
         pend_count_in  = count_in;
      end else if (state_ff == S_HOLD && rsp_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_head_in   = pend_head_ff;
         rsp_count_in  = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_count_ff   <= rsp_count_in;
      pend_status_ff <= pend_status_in;
      pend_head_ff   <= pend_head_in;
      pend_count_ff  <= pend_count_in;
   end

   // Chain of cells, head at cell zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  prev_valid;
      logic                  next_valid;
      logic [VALUE_BITS-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_value = cell_value[i];
      end else begin : g_link
         assign next_valid = cell_valid[i+1];
         assign next_value = cell_value[i+1];
      end

      frbv_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .shift_en   (shift_mask[i]),
         .din        (din),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_value (next_value),
         .valid      (cell_valid[i]),
         .value      (cell_value[i]),
         .match      (cell_match[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_value = rsp_head_ff;
   assign rsp_occupancy  = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/frbv_cell.sv @@
`default_nettype none

module frbv_cell #(
   parameter int VALUE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire frbv_pkg::cell_cmd_type   cmd,
   input  wire logic                     shift_en,
   input  wire logic [VALUE_BITS-1:0]    din,
   input  wire logic                     prev_valid,
   input  wire logic                     next_valid,
   input  wire logic [VALUE_BITS-1:0]    next_value,
   output logic                          valid,
   output logic [VALUE_BITS-1:0]         value,
   output logic                          match
);
   import frbv_pkg::*;

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  match_ff, match_in;

   // Take the neighbour's entry on a shift, else fill if this is the first free cell
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (shift_en) begin
         valid_in = next_valid;
         value_in = next_value;
      end else if (cmd.enq && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         value_in = din;
      end
   end

   // Hold the compare result until the shift step uses it
   assign match_in = cmd.capture ? (valid_ff && (value_ff == din)) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

@@ rtl/frbv_checker.sv @@
`default_nettype none

module frbv_checker #(
   parameter int DEPTH = 64
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire frbv_pkg::status_type             rsp_status,
   input wire logic [frbv_pkg::ValueWidth-1:0]  rsp_head_value,
   input wire logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy
);
   import frbv_pkg::*;

   localparam int CountBits = $clog2(DEPTH + 1);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_head_value) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // An empty status leaves nothing in the queue
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
      else $error("empty status with entries held");

   // A full status means every cell is in use
   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == CountBits'(DEPTH))
      else $error("full status below capacity");

   // A returned head only comes with a good status
   a_head_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_head_value != '0 |-> rsp_status == ST_OK)
      else $error("head value returned on a failed request");

   // Occupancy never exceeds the capacity
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CountBits'(DEPTH))
      else $error("occupancy beyond capacity");

endmodule

bind fifo_with_remove_by_value_top frbv_checker #(.DEPTH(DEPTH)) u_frbv_checker (.*);

`default_nettype wire

@@ tb/fifo_with_remove_by_value_top_tb.sv @@
module fifo_with_remove_by_value_top_tb;
   import frbv_pkg::*;

   localparam int DEPTH      = 64;
   localparam int VALUE_BITS = 16;
   localparam int OCC_BITS   = $clog2(DEPTH + 1);

   // Opcode three is not defined by the block; it must leave the queue as it is and answer OK
   localparam opcode_type OP_UNUSED = 2'd3;

   // Random segment kinds
   localparam int SEG_FILL  = 0;
   localparam int SEG_DRAIN = 1;
   localparam int SEG_MIX   = 2;

   typedef struct packed {
      opcode_type              opcode;
      logic [ValueWidth-1:0]   value;
   } handle_request_type;

   typedef struct packed {
      status_type              status;
      logic [ValueWidth-1:0]   head_value;
      logic [OCC_BITS-1:0]     occupancy;
   } handle_response_type;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   opcode_type               req_opcode = OP_ENQUEUE;
   logic [ValueWidth-1:0]    req_value  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready  = 1'b0;
   status_type               rsp_status;
   logic [ValueWidth-1:0]    rsp_head_value;
   logic [OCC_BITS-1:0]      rsp_occupancy;

   handle_request_type       pending_requests[$];
   handle_response_type      expected_responses[$];
   handle_request_type       driven_request;
   handle_response_type      seen_response;
   handle_response_type      wanted_response;

   // Two copies of the queue contents: one follows generation, one follows acceptance
   logic [ValueWidth-1:0]    stimulus_held[$];
   logic [ValueWidth-1:0]    predicted_held[$];

   int                       send_idle_pct  = 0;
   int                       recv_stall_pct = 0;
   int                       fail_count     = 0;
   int                       phase_requests;

   fifo_with_remove_by_value_top #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_head_value (rsp_head_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   // Apply one operation to a copy of the queue and return the response it yields
   function automatic handle_response_type apply_handle_op(ref logic [ValueWidth-1:0] held[$],
                                                           input handle_request_type rq);
      handle_response_type res;
      int                  hit;
      res.status     = ST_OK;
      res.head_value = '0;
      hit            = -1;
      case (rq.opcode)
         OP_ENQUEUE: begin
            if (held.size() >= DEPTH) res.status = ST_FULL;
            else held.push_back(rq.value);
         end
         OP_DEQUEUE: begin
            if (held.size() == 0) res.status = ST_EMPTY;
            else res.head_value = held.pop_front();
         end
         OP_REMOVE: begin
            if (held.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < held.size(); i++)
                  if (hit < 0 && held[i] == rq.value) hit = i;
               if (hit < 0) res.status = ST_NOTFOUND;
               else held.delete(hit);
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_BITS'(held.size());
      return res;
   endfunction

   function automatic logic [ValueWidth-1:0] pick_value();
      // Favour a small pool so duplicates and hits are common
      if ($urandom_range(0, 1) == 0) return ValueWidth'($urandom_range(0, 7));
      return ValueWidth'($urandom_range(0, (1 << ValueWidth) - 1));
   endfunction

   task automatic add_request(input opcode_type op, input logic [ValueWidth-1:0] val);
      handle_request_type rq;
      rq.opcode = op;
      rq.value  = val;
      void'(apply_handle_op(stimulus_held, rq));
      pending_requests.push_back(rq);
      if (op != OP_UNUSED) phase_requests++;
   endtask

   task automatic add_segment(input int kind);
      int len;
      int roll;
      case (kind)
         SEG_FILL: begin
            while (stimulus_held.size() < DEPTH) add_request(OP_ENQUEUE, pick_value());
            len = $urandom_range(1, 3);
            repeat (len) add_request(OP_ENQUEUE, pick_value());
            // remove at the tail and at the head of a full queue
            add_request(OP_REMOVE, stimulus_held[DEPTH-1]);
            add_request(OP_ENQUEUE, pick_value());
            add_request(OP_REMOVE, stimulus_held[0]);
         end
         SEG_DRAIN: begin
            while (stimulus_held.size() > 0) add_request(OP_DEQUEUE, pick_value());
            len = $urandom_range(1, 2);
            repeat (len) add_request(OP_DEQUEUE, pick_value());
         end
         default: begin
            len = $urandom_range(10, 30);
            repeat (len) begin
               roll = $urandom_range(0, 99);
               if (roll < 38)
                  add_request(OP_ENQUEUE, pick_value());
               else if (roll < 58)
                  add_request(OP_DEQUEUE, pick_value());
               else if (roll < 83 && stimulus_held.size() > 0)
                  add_request(OP_REMOVE,
                              stimulus_held[$urandom_range(0, stimulus_held.size() - 1)]);
               else if (roll < 97)
                  add_request(OP_REMOVE, pick_value());
               else
                  add_request(OP_UNUSED, pick_value());
            end
         end
      endcase
   endtask

   // Hold until every request is sent and every response has come back
   task automatic wait_until_idle();
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, what);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_responses.push_back(apply_handle_op(predicted_held, driven_request));
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               driven_request = pending_requests.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= driven_request.opcode;
               req_value  <= driven_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: match each response against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_response.status     = rsp_status;
            seen_response.head_value = rsp_head_value;
            seen_response.occupancy  = rsp_occupancy;
            if (expected_responses.size() == 0) begin
               note_failure($sformatf("unexpected response status=%0d head=%h occ=%0d",
                                      rsp_status, rsp_head_value, rsp_occupancy));
            end else begin
               wanted_response = expected_responses.pop_front();
               if (seen_response.status !== wanted_response.status ||
                   seen_response.head_value !== wanted_response.head_value ||
                   seen_response.occupancy !== wanted_response.occupancy)
                  note_failure($sformatf(
                     "mismatch: expected status=%0d head=%h occ=%0d, got status=%0d head=%h occ=%0d",
                     wanted_response.status, wanted_response.head_value,
                     wanted_response.occupancy, seen_response.status,
                     seen_response.head_value, seen_response.occupancy));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("[fifo_with_remove_by_value_top] ERROR");
      $finish;
   end

   initial begin
      int phase;
      int send_pcts[4];
      int stall_pcts[4];
      send_pcts  = '{0, 61, 0, 35};
      stall_pcts = '{0, 0, 61, 35};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty cases, extreme values, duplicates, head, middle and tail removal
      add_request(OP_DEQUEUE, 16'h0000);
      add_request(OP_REMOVE, 16'h0005);
      add_request(OP_UNUSED, 16'hFFFF);
      add_request(OP_ENQUEUE, 16'h0000);
      add_request(OP_ENQUEUE, 16'hFFFF);
      add_request(OP_ENQUEUE, 16'h1234);
      add_request(OP_ENQUEUE, 16'hFFFF);
      add_request(OP_ENQUEUE, 16'h00AA);
      add_request(OP_UNUSED, 16'h0000);
      add_request(OP_REMOVE, 16'h5555);
      add_request(OP_REMOVE, 16'hFFFF);
      add_request(OP_REMOVE, 16'h0000);
      add_request(OP_REMOVE, 16'h00AA);
      add_request(OP_DEQUEUE, 16'hFFFF);
      add_request(OP_DEQUEUE, 16'h0000);
      add_request(OP_DEQUEUE, 16'h0000);
      add_request(OP_ENQUEUE, 16'h8001);
      add_request(OP_REMOVE, 16'h8001);
      add_request(OP_REMOVE, 16'h8001);
      add_request(OP_ENQUEUE, 16'h7FFE);
      add_request(OP_DEQUEUE, 16'h0000);

      // Random phases, each with its own idling pattern; wait for every response between them
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = stall_pcts[phase];
         phase_requests = 0;
         if (phase == 0) add_segment(SEG_FILL);
         while (phase_requests < 80) begin
            case ($urandom_range(0, 99)) inside
               [0:7]:   add_segment(SEG_FILL);
               [8:15]:  add_segment(SEG_DRAIN);
               default: add_segment(SEG_MIX);
            endcase
         end
         wait_until_idle();
      end

      // Let any late response show up before judging
      repeat (20) @(negedge clock);
      if (fail_count == 0 && expected_responses.size() == 0)
         $display("[fifo_with_remove_by_value_top] OK");
      else
         $display("[fifo_with_remove_by_value_top] ERROR");
      $finish;
   end

endmodule
